### hdl/ats_pkg.sv
package ats_pkg;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CNT_W           = 9;
    localparam int WEIGHT_W        = 17;
    localparam int RAND_W          = 16;
    localparam int IDX_W           = 8;
    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DRAW     = 1'b1;
endpackage

### hdl/alias_table_sampler.sv
// Walker alias sampler, one request worked at a time. A draw reads the weight and alias
// memories, then compares, or goes straight to output index 0 with no built table; the
// block returns to idle and takes the next request once the result is accepted.
// A load registers the weight times n, then writes it. The final load adds a build pass:
// sort (read, write per entry), then pairing steps (two list reads, two weight reads, write).
// Reset (aresetn low, synchronous) clears control state; tables are undefined until built.
module alias_table_sampler #(
    parameter int MAX_ENTRIES = ats_pkg::MAX_ENTRIES_DEF,
    parameter int FRAC_BITS   = ats_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: weight[16:0], random_fraction[32:17], zero pad [39:33]
    input  logic [39:0] s_tdata,
    // tuser: mode
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: sample_index[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int NW  = AW + 1;
    localparam int SWW = FRAC_BITS + 8;
    localparam logic [SWW-1:0] ONE = SWW'(1) << FRAC_BITS;
    localparam logic [SWW-1:0] SMAX = {SWW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_DRAW_RD, ST_DRAW_CMP, ST_OUT,
        ST_SORT_RD, ST_SORT_WR, ST_PAIR_RD_LIST, ST_PAIR_RD_W, ST_PAIR_WR
    } state_t;

    // Memories: scaled weights, aliases and the small/large list.
    logic [SWW-1:0] wmem [MAX_ENTRIES];
    logic [AW-1:0]  amem [MAX_ENTRIES];
    logic [AW-1:0]  lmem [MAX_ENTRIES];

    state_t state_reg;
    logic [8:0]      cnt_reg;
    logic [NW-1:0]   load_pos_reg, small_tail_reg, large_head_reg, i_reg, m_reg;
    logic            ready_reg, last_reg;
    logic [SWW-1:0]  prod_reg, w_rd_reg, ws_reg;
    logic [AW-1:0]   a_rd_reg, s_reg, g_reg;
    logic [FRAC_BITS-1:0] f_reg;
    logic [AW-1:0]   pm_reg;
    logic [7:0]      out_reg;
    logic            phase_reg;

    // Active entry count with clamping.
    logic [NW-1:0] n;
    always_comb begin
        if (cnt_reg == 9'd0)
            n = NW'(1);
        else if (32'(cnt_reg) > MAX_ENTRIES)
            n = NW'(MAX_ENTRIES);
        else
            n = NW'(cnt_reg);
    end

    logic [16:0] in_weight;
    logic [FRAC_BITS-1:0] in_frac;
    assign in_weight = s_tdata[16:0];
    assign in_frac   = FRAC_BITS'(s_tdata[32:17] & 16'((33'(1) << FRAC_BITS) - 1));

    // Draw position: product of fraction and n, split into index and remainder.
    logic [FRAC_BITS+NW-1:0] pprod;
    logic [NW-1:0] pm_full;
    assign pprod   = (FRAC_BITS+NW)'(in_frac) * (FRAC_BITS+NW)'(n);
    assign pm_full = pprod[FRAC_BITS+NW-1:FRAC_BITS];

    logic [NW+17-1:0] wprod;
    assign wprod = (NW+17)'(in_weight) * (NW+17)'(n);

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;

    // In the pairing write cycle the read register holds the large entry's weight.
    logic [SWW:0] sum_w;
    assign sum_w = (SWW+1)'(w_rd_reg) + (SWW+1)'(ws_reg) - (SWW+1)'(ONE);

    // Memory ports.
    always_ff @(posedge aclk) begin
        w_rd_reg <= wmem[a_rd_reg];
        if (state_reg == ST_LOAD && load_pos_reg < n)
            wmem[load_pos_reg[AW-1:0]] <= prod_reg;
        else if (state_reg == ST_PAIR_WR)
            wmem[g_reg] <= sum_w[SWW-1:0];
    end
    logic [AW-1:0] alias_rd;
    always_ff @(posedge aclk) begin
        alias_rd <= amem[a_rd_reg];
        if (state_reg == ST_SORT_WR)
            amem[i_reg[AW-1:0]] <= '0;
        else if (state_reg == ST_PAIR_WR)
            amem[s_reg] <= g_reg;
    end
    logic [AW-1:0] list_rd;
    logic [NW-1:0] l_addr;
    always_ff @(posedge aclk) begin
        list_rd <= lmem[l_addr[AW-1:0]];
        if (state_reg == ST_SORT_WR) begin
            if (w_rd_reg < ONE)
                lmem[small_tail_reg[AW-1:0]] <= i_reg[AW-1:0];
            else
                lmem[AW'(large_head_reg - NW'(1))] <= i_reg[AW-1:0];
        end
    end
    assign l_addr = phase_reg ? large_head_reg : m_reg;

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 9'd256;
            load_pos_reg   <= '0;
            small_tail_reg <= '0;
            large_head_reg <= NW'(MAX_ENTRIES);
            ready_reg      <= 1'b0;
            last_reg       <= 1'b0;
            phase_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_we) begin
                        cnt_reg      <= cfg_wdata;
                        load_pos_reg <= '0;
                        ready_reg    <= 1'b0;
                    end else if (s_tvalid) begin
                        last_reg <= s_tlast;
                        if (s_tuser == ats_pkg::MODE_LOAD) begin
                            ready_reg <= 1'b0;
                            prod_reg  <= (wprod > (NW+17)'(SMAX)) ? SMAX : SWW'(wprod);
                            state_reg <= ST_LOAD;
                        end else begin
                            pm_reg   <= (pm_full >= n) ? AW'(n - NW'(1)) : AW'(pm_full);
                            f_reg    <= pprod[FRAC_BITS-1:0];
                            state_reg <= ready_reg ? ST_DRAW_RD : ST_OUT;
                            out_reg  <= '0;
                            a_rd_reg <= (pm_full >= n) ? AW'(n - NW'(1)) : AW'(pm_full);
                        end
                    end
                end
                ST_LOAD: begin
                    if (load_pos_reg < n)
                        load_pos_reg <= load_pos_reg + NW'(1);
                    if (last_reg) begin
                        small_tail_reg <= '0;
                        large_head_reg <= n;
                        i_reg    <= '0;
                        a_rd_reg <= '0;
                        state_reg <= ST_SORT_RD;
                    end else
                        state_reg <= ST_IDLE;
                end
                ST_DRAW_RD: state_reg <= ST_DRAW_CMP;
                ST_DRAW_CMP: begin
                    // Compare the fraction against the stored weight: below it keeps the entry, else its alias.
                    out_reg <= 8'((SWW'(f_reg) < w_rd_reg) ? pm_reg : alias_rd);
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (m_tready) state_reg <= ST_IDLE;
                ST_SORT_RD: state_reg <= ST_SORT_WR;
                ST_SORT_WR: begin
                    if (w_rd_reg < ONE)
                        small_tail_reg <= small_tail_reg + NW'(1);
                    else
                        large_head_reg <= large_head_reg - NW'(1);
                    if (i_reg + NW'(1) >= n) begin
                        load_pos_reg <= '0;
                        m_reg     <= '0;
                        phase_reg <= 1'b0;
                        if ((small_tail_reg != '0 || w_rd_reg < ONE) &&
                            (large_head_reg != n || !(w_rd_reg < ONE)) && n > NW'(1))
                            state_reg <= ST_PAIR_RD_LIST;
                        else begin
                            ready_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        i_reg    <= i_reg + NW'(1);
                        a_rd_reg <= AW'(i_reg + NW'(1));
                        state_reg <= ST_SORT_RD;
                    end
                end
                ST_PAIR_RD_LIST: begin
                    // Two list reads: small entry then large head.
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        s_reg     <= list_rd;
                        a_rd_reg  <= list_rd;
                        phase_reg <= 1'b0;
                        state_reg <= ST_PAIR_RD_W;
                    end
                end
                ST_PAIR_RD_W: begin
                    if (!phase_reg) begin
                        g_reg     <= list_rd;
                        a_rd_reg  <= list_rd;
                        phase_reg <= 1'b1;
                    end else begin
                        ws_reg    <= w_rd_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_PAIR_WR;
                    end
                end
                ST_PAIR_WR: begin
                    if (sum_w[SWW-1:0] < ONE && !sum_w[SWW])
                        large_head_reg <= large_head_reg + NW'(1);
                    if ((sum_w[SWW-1:0] < ONE && !sum_w[SWW] &&
                         large_head_reg + NW'(1) >= n) || m_reg + NW'(2) >= n) begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        m_reg     <= m_reg + NW'(1);
                        state_reg <= ST_PAIR_RD_LIST;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The pad bits of a request carry nothing.
    logic unused_ok;
    assign unused_ok = ^{s_tdata[39:33]};
endmodule

### hdl/alias_table_sampler_checker.sv
module alias_table_sampler_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    // A result waiting must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");
    // No new request while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during output");
    // Reset leaves output idle.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind alias_table_sampler alias_table_sampler_checker u_chk (.*);

### tb/alias_table_sampler_tb.sv
`timescale 1ns / 1ps

module alias_table_sampler_tb;

    // Alias table model and the queue of samples still owed by the block.
    class alias_scoreboard;
        bit [23:0]  scaled_w [256];
        bit [7:0]   alias_of [256];
        bit [8:0]   count_reg;
        int         load_pos;
        bit         ready;
        bit         written [256];
        bit [8:0]   pending_idx [$];
        int         errors;
        int         samples;

        function new();
            count_reg = 9'd256;
            load_pos  = 0;
            ready     = 0;
            errors    = 0;
            samples   = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function int outcomes();
            if (count_reg == 0) return 1;
            if (count_reg > 256) return 256;
            return count_reg;
        endfunction

        function void set_count(bit [8:0] v);
            count_reg = v;
            load_pos  = 0;
            ready     = 0;
        endfunction

        // Sort into underweight and overweight lists, then pair them off.
        function void build_table(int n);
            int lists [256];
            int lo_tail, hi_head, s, g;
            lo_tail = 0;
            hi_head = n;
            for (int i = 0; i < n; i++) begin
                alias_of[i] = 0;
                if (scaled_w[i] < 24'h10000) begin
                    lists[lo_tail] = i;
                    lo_tail++;
                end else begin
                    hi_head--;
                    lists[hi_head] = i;
                end
            end
            if (lo_tail > 0 && hi_head < n) begin
                for (int m = 0; m + 1 < n; m++) begin
                    s = lists[m];
                    g = lists[hi_head];
                    alias_of[s] = g[7:0];
                    scaled_w[g] = scaled_w[g] + scaled_w[s] - 24'h10000;
                    if (scaled_w[g] < 24'h10000) hi_head++;
                    if (hi_head >= n) break;
                end
            end
        endfunction

        function void note_request(bit mode, bit [16:0] weight, bit [15:0] frac, bit fin);
            int n;
            bit [31:0] prod, p, m, f;
            bit [7:0] idx;
            n = outcomes();
            if (mode == ats_pkg::MODE_LOAD) begin
                ready = 0;
                if (load_pos < n) begin
                    prod = weight * n;
                    scaled_w[load_pos] = (prod > 32'hFFFFFF) ? 24'hFFFFFF : prod[23:0];
                    written[load_pos]  = 1;
                    load_pos++;
                end
                if (fin) begin
                    build_table(n);
                    load_pos = 0;
                    ready    = 1;
                end
            end else begin
                idx = 0;
                if (ready) begin
                    p = frac * n;
                    m = p >> 16;
                    if (m >= n) m = n - 1;
                    f = p - (m << 16);
                    idx = (f < scaled_w[m]) ? m[7:0] : alias_of[m];
                end
                pending_idx.push_back({fin, idx});
            end
        endfunction

        task check_result(bit [7:0] idx, bit last);
            bit [8:0] exp_v;
            samples++;
            if (pending_idx.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d last %0b", idx, last));
                return;
            end
            exp_v = pending_idx.pop_front();
            if (idx !== exp_v[7:0])
                report_mismatch($sformatf("sample_index %0d, expected %0d", idx, exp_v[7:0]));
            if (last !== exp_v[8])
                report_mismatch($sformatf("last %0b, expected %0b", last, exp_v[8]));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [8:0]  cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    alias_scoreboard sb = new();
    bit  steady = 0;
    int  requests = 0;
    int  phases = 0;

    alias_table_sampler dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Result side: check every accepted sample and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        m_tready <= steady || ($urandom_range(99) >= 17);
    end

    task automatic send_request(bit mode, bit [16:0] weight, bit [15:0] frac, bit fin);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tlast  <= fin;
        s_tdata  <= {7'd0, frac, weight};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, weight, frac, fin);
        requests++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_idx.size() != 0) @(posedge aclk);
    endtask

    // Registers change only with the block idle, and after any build has finished.
    task automatic write_count(bit [8:0] v);
        drain();
        do @(posedge aclk); while (!s_tready);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 0;
        sb.set_count(v);
    endtask

    // Load a full table; mostly normalized weights, sometimes arbitrary ones.
    task automatic load_table(int extra, bit normalized);
        int n, sum, acc;
        int raw [256];
        bit [16:0] w;
        n = sb.outcomes();
        sum = 0;
        for (int i = 0; i < n; i++) begin
            raw[i] = $urandom_range(1000);
            sum += raw[i];
        end
        if (sum == 0) begin
            raw[0] = 1;
            sum = 1;
        end
        acc = 0;
        for (int i = 0; i < n + extra; i++) begin
            if (i >= n) w = 17'($urandom_range(65536));
            else if (!normalized) w = 17'($urandom_range(65536));
            else if (i == n - 1) w = 17'(65536 - acc);
            else begin
                w = 17'((raw[i] * 65536) / sum);
                acc += w;
            end
            send_request(ats_pkg::MODE_LOAD, w, 16'($urandom), i == n + extra - 1);
        end
    endtask

    task automatic draw_batch(int k);
        for (int i = 0; i < k; i++)
            send_request(ats_pkg::MODE_DRAW, 17'($urandom), 16'($urandom),
                         (i == k - 1) || ($urandom_range(7) == 0));
    endtask

    initial begin
        bit [8:0] cnt;
        bit all_written;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: draws with no table, then a single-entry table.
        send_request(ats_pkg::MODE_DRAW, 17'h1FFFF, 16'hFFFF, 0);
        send_request(ats_pkg::MODE_DRAW, 0, 0, 1);
        write_count(0);
        send_request(ats_pkg::MODE_LOAD, 17'h10000, 16'hFFFF, 1);
        send_request(ats_pkg::MODE_DRAW, 0, 16'hFFFF, 0);
        send_request(ats_pkg::MODE_DRAW, 0, 0, 1);
        // Extra loads past n are dropped; a load without final drops readiness.
        write_count(2);
        send_request(ats_pkg::MODE_LOAD, 17'h08000, 0, 0);
        send_request(ats_pkg::MODE_LOAD, 17'h08000, 0, 0);
        send_request(ats_pkg::MODE_LOAD, 17'h1FFFF, 0, 1);
        send_request(ats_pkg::MODE_DRAW, 0, 16'h7FFF, 0);
        send_request(ats_pkg::MODE_DRAW, 0, 16'h8000, 1);
        send_request(ats_pkg::MODE_LOAD, 17'h10000, 0, 0);
        send_request(ats_pkg::MODE_DRAW, 0, 16'hC000, 1);
        // A final load that completes the refill writes the second weight and rebuilds.
        send_request(ats_pkg::MODE_LOAD, 0, 0, 1);
        draw_batch(4);
        // Full range: saturating scaled weights with all 256 entries.
        write_count(511);
        for (int i = 0; i < 256; i++)
            send_request(ats_pkg::MODE_LOAD, (i < 2) ? 17'h10000 : 17'd0, 0, i == 255);
        draw_batch(8);
        write_count(256);
        load_table(0, 1);
        draw_batch(8);

        // Random phases, most with small tables.
        while (requests < 1650) begin
            phases++;
            steady = (phases >= 20 && phases < 30);
            case ($urandom_range(9))
                0: cnt = 9'(256 + $urandom_range(255));
                1: cnt = $urandom_range(1) ? 9'd1 : 9'd0;
                2: cnt = 9'($urandom_range(64, 200));
                default: cnt = 9'($urandom_range(2, 12));
            endcase
            write_count(cnt);
            load_table(($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0,
                       $urandom_range(4) != 0);
            draw_batch($urandom_range(10, 30));
            if (phases == 7) drain();
            // Broken sequence: a short reload, finalized only if old weights are valid.
            if ($urandom_range(5) == 0) begin
                send_request(ats_pkg::MODE_LOAD, 17'($urandom_range(65536)),
                             16'($urandom), 0);
                draw_batch($urandom_range(1, 3));
                all_written = 1;
                for (int i = 0; i < sb.outcomes(); i++)
                    if (!sb.written[i]) all_written = 0;
                if (all_written) begin
                    send_request(ats_pkg::MODE_LOAD, 17'($urandom_range(65536)),
                                 16'($urandom), 1);
                    draw_batch($urandom_range(5, 15));
                end
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("Ran %0d requests over %0d table phases, %0d samples checked.",
                 requests, phases, sb.samples);
        $display("Covered empty-table draws, dropped loads, saturation and 1 to 256 entries.");
        if (sb.errors == 0 && sb.pending_idx.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (sb.pending_idx.size() != 0)
                $display("%0d samples never arrived", sb.pending_idx.size());
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Timeout with %0d samples outstanding", sb.pending_idx.size());
        $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
hdl/ats_pkg.sv
hdl/alias_table_sampler.sv
hdl/alias_table_sampler_checker.sv
tb/alias_table_sampler_tb.sv
